// ===== design/imtc_pkg.sv =====
// Shared types, codes and constants of the IPv4 address and netmask line classifier.
`default_nettype none

package imtc_pkg;

  // Result categories, also the index of the counter each one bumps (CAT_IGNORED bumps none).
  localparam logic [2:0] CAT_A       = 3'd0;
  localparam logic [2:0] CAT_B       = 3'd1;
  localparam logic [2:0] CAT_C       = 3'd2;
  localparam logic [2:0] CAT_D       = 3'd3;
  localparam logic [2:0] CAT_E       = 3'd4;
  localparam logic [2:0] CAT_INVALID = 3'd5;
  localparam logic [2:0] CAT_IGNORED = 3'd6;

  // The private-range counter sits after the five classes and the invalid count.
  localparam logic [2:0] IDX_PRIVATE = 3'd6;
  localparam int unsigned NUM_COUNTERS = 7;

  // Characters of the line syntax.
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_TILDE = 8'h7E;

  localparam logic [11:0] OCTET_MAX   = 12'd255;
  localparam logic [7:0]  OCTET_LOOP  = 8'd127;
  localparam logic [7:0]  OCTET_PRIV_A = 8'd10;
  localparam logic [7:0]  OCTET_PRIV_B = 8'd172;
  localparam logic [7:0]  OCTET_PRIV_C = 8'd192;
  localparam logic [7:0]  OCTET_PRIV_C2 = 8'd168;

  localparam int unsigned COUNT_WIDTH_DEFAULT = 32;
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;
  localparam int unsigned OUT_COUNT_WIDTH     = 32;

  // One classified line as it travels from the parser to the counters.
  typedef struct packed {
    logic [2:0] category;
    logic       is_private;
  } line_res_t;

endpackage

`default_nettype wire

// ===== design/imtc_front.sv =====
// Character parser and line classifier: one character per cycle while char_acc is high, one verdict per line.
`default_nettype none

module imtc_front
  import imtc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       char_acc,
  input  wire logic [7:0] char_code,
  input  wire logic       end_of_line,
  output line_res_t       res,
  output logic            res_push
);

  typedef struct packed {
    logic [3:0]  field_number;
    logic [8:0]  field_value;
    logic        digit_seen;
    logic        line_error;
    logic [7:0]  first_octet;
    logic [7:0]  second_octet;
    logic [31:0] mask_word;
  } line_state_t;

  line_state_t st_r, st_nxt;

  function automatic line_state_t close_field(input line_state_t s);
    line_state_t o;
    logic [7:0]  v;
    o = s;
    v = s.field_value[7:0];
    if (s.field_number == 4'd0) begin
      o.first_octet = v;
    end else if (s.field_number == 4'd1) begin
      o.second_octet = v;
    end else if (s.field_number[3:2] == 2'b01) begin
      unique case (s.field_number[1:0])
        2'd0: o.mask_word[31:24] = s.mask_word[31:24] | v;
        2'd1: o.mask_word[23:16] = s.mask_word[23:16] | v;
        2'd2: o.mask_word[15:8]  = s.mask_word[15:8]  | v;
        2'd3: o.mask_word[7:0]   = s.mask_word[7:0]   | v;
        default: o.mask_word = s.mask_word;
      endcase
    end
    if (s.field_number != 4'hF) begin
      o.field_number = s.field_number + 4'd1;
    end
    o.field_value = '0;
    o.digit_seen  = 1'b0;
    return o;
  endfunction

  function automatic logic mask_ok(input logic [31:0] m);
    logic [31:0] inv;
    inv = ~m;
    return (m != '0) && (m != '1) && ((inv & (inv + 32'd1)) == '0);
  endfunction

  line_state_t s;
  logic [11:0] new_value;
  logic        is_digit;
  logic        is_sep;
  line_res_t   verdict;

  always_comb begin
    s         = st_r;
    is_digit  = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
    is_sep    = (char_code == CHAR_DOT) || (char_code == CHAR_TILDE);
    new_value = 12'(st_r.field_value) * 12'd10 + 12'(char_code - CHAR_ZERO);

    if (!st_r.line_error) begin
      if (is_digit) begin
        s.digit_seen = 1'b1;
        if (new_value > OCTET_MAX) begin
          s.line_error = 1'b1;
        end else begin
          s.field_value = new_value[8:0];
        end
      end else if (is_sep) begin
        if (st_r.digit_seen) begin
          s = close_field(st_r);
        end else begin
          s.line_error = 1'b1;
        end
      end else begin
        s.line_error = 1'b1;
      end
    end

    // The last field of a line is closed by the line end itself.
    if (end_of_line && !s.line_error && s.digit_seen) begin
      s = close_field(s);
    end

    verdict.is_private = 1'b0;
    if (s.line_error) begin
      verdict.category = CAT_INVALID;
    end else if ((s.first_octet == 8'd0) || (s.first_octet == OCTET_LOOP)) begin
      verdict.category = CAT_IGNORED;
    end else if ((s.field_number < 4'd8) || !mask_ok(s.mask_word)) begin
      verdict.category = CAT_INVALID;
    end else begin
      priority if (s.first_octet <= 8'd126) begin
        verdict.category = CAT_A;
      end else if (s.first_octet <= 8'd191) begin
        verdict.category = CAT_B;
      end else if (s.first_octet <= 8'd223) begin
        verdict.category = CAT_C;
      end else if (s.first_octet <= 8'd239) begin
        verdict.category = CAT_D;
      end else begin
        verdict.category = CAT_E;
      end
      verdict.is_private =
        (s.first_octet == OCTET_PRIV_A) ||
        ((s.first_octet == OCTET_PRIV_B) && (s.second_octet >= 8'd16) &&
         (s.second_octet <= 8'd31)) ||
        ((s.first_octet == OCTET_PRIV_C) && (s.second_octet == OCTET_PRIV_C2));
    end

    st_nxt = st_r;
    if (char_acc) begin
      st_nxt = end_of_line ? line_state_t'('0) : s;
    end
  end

  assign res      = verdict;
  assign res_push = char_acc && end_of_line;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Once a line has failed to parse, only its end may clear the error.
  a_error_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (char_acc && !end_of_line && st_r.line_error) |=> st_r.line_error)
    else $error("line error cleared before the end of the line");

endmodule

`default_nettype wire

// ===== design/imtc_queue.sv =====
// Short queue of classified lines between the parser and the counter stage.
`default_nettype none

module imtc_queue
  import imtc_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_push,
  input  line_res_t q_in,
  output logic      q_full,
  input  wire logic q_pop,
  output line_res_t q_head,
  output logic      q_empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  line_res_t          mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign q_full  = (count_r == CNT_W'(DEPTH));
  assign q_empty = (count_r == '0);
  assign do_push = q_push && !q_full;
  assign do_pop  = q_pop && !q_empty;
  assign q_head  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= q_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue fill count above depth");

  a_count_push: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && !q_full && !q_pop) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("queue fill count missed a push");

endmodule

`default_nettype wire

// ===== design/imtc_back.sv =====
// Saturating category counters and the result register.
`default_nettype none

module imtc_back
  import imtc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  line_res_t  head,
  input  wire logic  head_valid,
  output logic       head_pop,
  output logic       out_valid,
  input  wire logic  out_pop,
  output logic [2:0] out_category,
  output logic       out_is_private,
  output logic [OUT_COUNT_WIDTH-1:0] out_counts [NUM_COUNTERS]
);

  logic [COUNT_WIDTH-1:0]     cnt_r   [NUM_COUNTERS];
  logic [COUNT_WIDTH-1:0]     cnt_nxt [NUM_COUNTERS];
  logic [OUT_COUNT_WIDTH-1:0] snap_r  [NUM_COUNTERS];
  logic [63:0]                wide    [NUM_COUNTERS];
  logic                       valid_r;
  logic [2:0]                 cat_r;
  logic                       priv_r;
  logic                       load;

  // A new line moves in when the result slot is free or being emptied now.
  assign load     = head_valid && (!valid_r || out_pop);
  assign head_pop = load;

  always_comb begin
    for (int k = 0; k < NUM_COUNTERS; k++) begin
      cnt_nxt[k] = cnt_r[k];
      if ((((head.category == 3'(k)) && (head.category != CAT_IGNORED)) ||
           ((3'(k) == IDX_PRIVATE) && head.is_private)) && (cnt_r[k] != '1)) begin
        cnt_nxt[k] = cnt_r[k] + COUNT_WIDTH'(1);
      end
      wide[k] = 64'(cnt_nxt[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      for (int k = 0; k < NUM_COUNTERS; k++) begin
        cnt_r[k] <= '0;
      end
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        for (int k = 0; k < NUM_COUNTERS; k++) begin
          cnt_r[k] <= cnt_nxt[k];
        end
      end else if (out_pop) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cat_r  <= head.category;
      priv_r <= head.is_private;
      for (int k = 0; k < NUM_COUNTERS; k++) begin
        snap_r[k] <= wide[k][OUT_COUNT_WIDTH-1:0];
      end
    end
  end

  assign out_valid      = valid_r;
  assign out_category   = cat_r;
  assign out_is_private = priv_r;
  assign out_counts     = snap_r;

  a_ignored_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    (load && (head.category == CAT_IGNORED)) |=>
      ((cnt_r[CAT_A] == $past(cnt_r[CAT_A])) &&
       (cnt_r[CAT_INVALID] == $past(cnt_r[CAT_INVALID])) &&
       (cnt_r[IDX_PRIVATE] == $past(cnt_r[IDX_PRIVATE]))))
    else $error("ignored line changed a counter");

  a_private_class: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && priv_r) |->
      ((cat_r == CAT_A) || (cat_r == CAT_B) || (cat_r == CAT_C)))
    else $error("private flag on a line outside classes A to C");

endmodule

`default_nettype wire

// ===== design/ipv4_mask_text_classifier.sv =====
// Top level of the IPv4 address and netmask line classifier.
`default_nettype none

// The block reads text lines of the form "a.b.c.d~m.m.m.m" one character per
// item and gives one result for each line, at the character flagged as the end
// of the line. A character is taken in every cycle in which push is high and
// full is low, so a stream runs at one character per clock; the parser closes
// the last field, checks the mask and classifies the address in the same cycle
// as the closing character. Each verdict then waits in a QUEUE_DEPTH-entry
// queue (four by default), and a counter stage bumps the saturating counters
// and loads the result register, where the result of a line shows on the out_
// ports and stays until popped. The category is 0 to 4 for classes A to E, 5
// for a line with a parse error, fewer than eight fields or a bad mask, and 6
// for a line whose first octet is 0 or 127 (such lines leave the counters alone
// unless they failed to parse). Full rises only once the queue holds QUEUE_DEPTH
// finished lines that the consumer has not yet taken; characters that do not
// end a line are held back at that point as well. The counters are COUNT_WIDTH
// bits wide, saturate at their maximum and are shown in 32 bits.

module ipv4_mask_text_classifier
  import imtc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEFAULT,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_char_code,
  input  wire logic        in_end_of_line,
  output logic             empty,
  input  wire logic        pop,
  output logic [2:0]       out_category,
  output logic             out_is_private,
  output logic [31:0]      out_count_class_a,
  output logic [31:0]      out_count_class_b,
  output logic [31:0]      out_count_class_c,
  output logic [31:0]      out_count_class_d,
  output logic [31:0]      out_count_class_e,
  output logic [31:0]      out_count_invalid,
  output logic [31:0]      out_count_private
);

  line_res_t                  line_res;
  line_res_t                  q_head;
  logic                       line_push;
  logic                       q_full;
  logic                       q_empty;
  logic                       q_pop;
  logic                       char_acc;
  logic                       out_valid;
  logic [OUT_COUNT_WIDTH-1:0] counts [NUM_COUNTERS];

  // Every character waits on the queue, so that a line end is never refused
  // after the characters before it went through.
  assign full     = q_full;
  assign char_acc = push && !q_full;

  imtc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .char_acc    (char_acc),
    .char_code   (in_char_code),
    .end_of_line (in_end_of_line),
    .res         (line_res),
    .res_push    (line_push)
  );

  imtc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (line_push),
    .q_in    (line_res),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_head  (q_head),
    .q_empty (q_empty)
  );

  imtc_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (q_head),
    .head_valid     (!q_empty),
    .head_pop       (q_pop),
    .out_valid      (out_valid),
    .out_pop        (pop),
    .out_category   (out_category),
    .out_is_private (out_is_private),
    .out_counts     (counts)
  );

  assign empty             = !out_valid;
  assign out_count_class_a = counts[CAT_A];
  assign out_count_class_b = counts[CAT_B];
  assign out_count_class_c = counts[CAT_C];
  assign out_count_class_d = counts[CAT_D];
  assign out_count_class_e = counts[CAT_E];
  assign out_count_invalid = counts[CAT_INVALID];
  assign out_count_private = counts[IDX_PRIVATE];

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the IPv4 address and netmask line classifier.
`default_nettype none

// The bench sends text lines to the classifier one character per item. A
// scoreboard object keeps its own copy of the parser state and the seven
// running counters, so it can work out the verdict of each line when the
// character that ends the line is taken. Every popped result is then compared,
// field by field, with the oldest verdict still waiting.
//
// A short directed part comes first. It covers the extreme byte values, an
// ignored first octet, a parse error ahead of a zero first octet, a value over
// 255, an empty field, a trailing separator and more than eight fields. The
// random part that follows is mostly well-formed lines with random content.
// The rest is broken lines and noise. Both sides idle in short random bursts,
// except in the last stretch of the run.

module testbench
  import imtc_pkg::*;
();

  localparam int unsigned WATCHDOG_CYCLES = 200;
  localparam int unsigned RANDOM_CHARS    = 1750;
  localparam int unsigned CALM_CHARS      = 300;

  // One verdict as the classifier should present it on the out_ ports.
  typedef struct packed {
    bit [2:0]       cat;
    bit             priv;
    bit [6:0][31:0] cnt;
  } verdict_t;

  // Tracks the parser and the counters, and holds the verdicts not yet popped.
  class line_scoreboard;
    bit [3:0]  fnum;
    bit [8:0]  fval;
    bit        seen;
    bit        err;
    bit [7:0]  oct1;
    bit [7:0]  oct2;
    bit [31:0] mask;
    bit [31:0] tally [7];
    verdict_t  due [$];
    int unsigned errors;

    function new();
      reset_line();
      foreach (tally[i]) tally[i] = 0;
      errors = 0;
    endfunction

    function void reset_line();
      fnum = 0;
      fval = 0;
      seen = 0;
      err  = 0;
      oct1 = 0;
      oct2 = 0;
      mask = 0;
    endfunction

    function void close_field();
      if (fnum == 0) oct1 = fval[7:0];
      else if (fnum == 1) oct2 = fval[7:0];
      else if (fnum >= 4 && fnum <= 7) mask |= {24'b0, fval[7:0]} << (8 * (7 - int'(fnum)));
      if (fnum < 15) fnum++;
      fval = 0;
      seen = 0;
    endfunction

    function bit mask_good(bit [31:0] m);
      bit [31:0] inv;
      inv = ~m;
      return (m != 32'h0) && (m != 32'hFFFF_FFFF) && ((inv & (inv + 32'd1)) == 32'h0);
    endfunction

    function void bump(int unsigned idx);
      if (tally[idx] != 32'hFFFF_FFFF) tally[idx]++;
    endfunction

    function void note_char(bit [7:0] c, bit eol);
      bit [11:0] nv;
      bit [2:0]  cat;
      bit        priv;
      verdict_t  v;
      if (!err) begin
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
          nv = {3'b0, fval} * 12'd10 + {4'b0, c - CHAR_ZERO};
          seen = 1;
          if (nv > OCTET_MAX) err = 1;
          else fval = nv[8:0];
        end else if (c == CHAR_DOT || c == CHAR_TILDE) begin
          if (seen) close_field();
          else err = 1;
        end else begin
          err = 1;
        end
      end
      if (!eol) return;
      if (!err && seen) close_field();
      priv = 0;
      if (err) begin
        cat = CAT_INVALID;
      end else if (oct1 == 8'd0 || oct1 == OCTET_LOOP) begin
        cat = CAT_IGNORED;
      end else if (fnum < 8 || !mask_good(mask)) begin
        cat = CAT_INVALID;
      end else begin
        if (oct1 <= 8'd126) cat = CAT_A;
        else if (oct1 <= 8'd191) cat = CAT_B;
        else if (oct1 <= 8'd223) cat = CAT_C;
        else if (oct1 <= 8'd239) cat = CAT_D;
        else cat = CAT_E;
        priv = (oct1 == OCTET_PRIV_A) ||
               (oct1 == OCTET_PRIV_B && oct2 >= 8'd16 && oct2 <= 8'd31) ||
               (oct1 == OCTET_PRIV_C && oct2 == OCTET_PRIV_C2);
      end
      if (cat != CAT_IGNORED) bump(32'(cat));
      if (priv) bump(32'(IDX_PRIVATE));
      v.cat  = cat;
      v.priv = priv;
      for (int i = 0; i < 7; i++) v.cnt[i] = tally[i];
      due.insert(due.size(), v);
      reset_line();
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(verdict_t got);
      verdict_t want;
      if (due.size() == 0) begin
        report("result popped while no line was waiting");
        return;
      end
      want = due.pop_front();
      if (got.cat != want.cat)
        report($sformatf("category got %0d want %0d", got.cat, want.cat));
      if (got.priv != want.priv)
        report($sformatf("is_private got %0d want %0d", got.priv, want.priv));
      for (int i = 0; i < 7; i++)
        if (got.cnt[i] != want.cnt[i])
          report($sformatf("counter %0d got %0d want %0d", i, got.cnt[i], want.cnt[i]));
    endtask

    function int pending();
      return due.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        pop = 1'b0;
  logic [7:0]  in_char_code = 8'h00;
  logic        in_end_of_line = 1'b0;
  wire logic        full;
  wire logic        empty;
  wire logic [2:0]  out_category;
  wire logic        out_is_private;
  wire logic [31:0] out_count_class_a;
  wire logic [31:0] out_count_class_b;
  wire logic [31:0] out_count_class_c;
  wire logic [31:0] out_count_class_d;
  wire logic [31:0] out_count_class_e;
  wire logic [31:0] out_count_invalid;
  wire logic [31:0] out_count_private;

  ipv4_mask_text_classifier dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_char_code      (in_char_code),
    .in_end_of_line    (in_end_of_line),
    .empty             (empty),
    .pop               (pop),
    .out_category      (out_category),
    .out_is_private    (out_is_private),
    .out_count_class_a (out_count_class_a),
    .out_count_class_b (out_count_class_b),
    .out_count_class_c (out_count_class_c),
    .out_count_class_d (out_count_class_d),
    .out_count_class_e (out_count_class_e),
    .out_count_invalid (out_count_invalid),
    .out_count_private (out_count_private)
  );

  line_scoreboard sb;
  bit [7:0]    text [$];
  bit          idle_on = 1'b0;
  int unsigned chars_sent = 0;
  int unsigned stall_left = 0;
  int unsigned quiet = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // The consumer side. Pop is now and then lowered at random, and
  // stays high throughout whenever idling is switched off.
  always @(negedge clk) begin
    if (rst_n) begin
      if (stall_left > 0) begin
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        pop = 1'b0;
        stall_left = $urandom_range(0, 4);
      end else begin
        pop = 1'b1;
      end
    end
  end

  // Popped results are checked at the rising edge, where the outputs still
  // hold the values they had before the edge. The watchdog ends the run when
  // no item has moved on either side for too long.
  always @(posedge clk) begin
    verdict_t got;
    if (rst_n) begin
      if (pop && !empty) begin
        got.cat  = out_category;
        got.priv = out_is_private;
        got.cnt  = {out_count_private, out_count_invalid, out_count_class_e,
                    out_count_class_d, out_count_class_c, out_count_class_b,
                    out_count_class_a};
        sb.check_result(got);
      end
      if ((push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_CYCLES) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Sends one character. The task is entered at a falling edge and returns at
  // the falling edge after the item was taken. Push is left high, so a
  // following item keeps the stream going without a gap.
  task send_char(bit [7:0] c, bit eol);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      push = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    push = 1'b1;
    in_char_code = c;
    in_end_of_line = eol;
    forever begin
      @(posedge clk);
      if (!full) break;
    end
    sb.note_char(c, eol);
    chars_sent++;
    @(negedge clk);
  endtask

  task send_line();
    for (int i = 0; i < text.size(); i++) send_char(text[i], i == text.size() - 1);
    text.delete();
  endtask

  // Appends one character to the line being built.
  function void add_char(bit [7:0] c);
    text.insert(text.size(), c);
  endfunction

  task put_text(string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endtask

  // Writes a decimal number, now and then with a leading zero in front.
  task put_num(int unsigned v);
    if ($urandom_range(0, 15) == 0) add_char(CHAR_ZERO);
    put_text($sformatf("%0d", v));
  endtask

  // Either separator closes a field, so the usual one is now and then swapped.
  function bit [7:0] pick_sep(bit [7:0] usual);
    if ($urandom_range(0, 9) != 0) return usual;
    return (usual == CHAR_DOT) ? CHAR_TILDE : CHAR_DOT;
  endfunction

  function bit [31:0] pick_mask();
    bit [31:0] m;
    m = 32'hFFFF_FFFF << (32 - $urandom_range(1, 31));
    case ($urandom_range(0, 11))
      0: m = 32'h0;
      1: m = 32'hFFFF_FFFF;
      2: m = $urandom;
      3: m = m ^ (32'd1 << $urandom_range(0, 31));
      4: m = {8'hFF, 8'd191, 16'h0};
      5: m = {8'hFF, 8'd192, 16'h0};
      default: ;
    endcase
    return m;
  endfunction

  // A line of the form a.b.c.d~m.m.m.m. The first octet leans towards the
  // class borders, the private ranges and the ignored values.
  task put_good_line();
    bit [7:0]  a [4];
    bit [31:0] m;
    case ($urandom_range(0, 9))
      0: a[0] = OCTET_PRIV_A;
      1: a[0] = OCTET_PRIV_B;
      2: a[0] = OCTET_PRIV_C;
      3: a[0] = $urandom_range(0, 1) ? OCTET_LOOP : 8'd0;
      4: begin
        case ($urandom_range(0, 8))
          0: a[0] = 8'd1;
          1: a[0] = 8'd126;
          2: a[0] = 8'd128;
          3: a[0] = 8'd191;
          4: a[0] = 8'd223;
          5: a[0] = 8'd224;
          6: a[0] = 8'd239;
          7: a[0] = 8'd240;
          default: a[0] = 8'd255;
        endcase
      end
      default: a[0] = 8'($urandom_range(1, 255));
    endcase
    if (a[0] == OCTET_PRIV_B && $urandom_range(0, 3) != 0) a[1] = 8'($urandom_range(12, 35));
    else if (a[0] == OCTET_PRIV_C && $urandom_range(0, 2) != 0) a[1] = OCTET_PRIV_C2;
    else a[1] = 8'($urandom_range(0, 255));
    a[2] = 8'($urandom_range(0, 255));
    a[3] = 8'($urandom_range(0, 255));
    m = pick_mask();
    for (int i = 0; i < 4; i++) begin
      put_num(a[i]);
      add_char(pick_sep(i == 3 ? CHAR_TILDE : CHAR_DOT));
    end
    for (int i = 0; i < 4; i++) begin
      put_num(m[31 - 8 * i -: 8]);
      if (i < 3) add_char(pick_sep(CHAR_DOT));
    end
    case ($urandom_range(0, 7))
      0: add_char(pick_sep(CHAR_DOT));
      1: repeat ($urandom_range(1, 3)) begin
        add_char(pick_sep(CHAR_DOT));
        put_num($urandom_range(0, 255));
      end
      default: ;
    endcase
  endtask

  task put_broken_line();
    case ($urandom_range(0, 4))
      0: begin
        // Cut short, so the line ends early or in the middle of a field.
        put_good_line();
        repeat ($urandom_range(1, text.size() - 1)) text.delete(text.size() - 1);
      end
      1: begin
        put_good_line();
        text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
      end
      2: begin
        put_good_line();
        text.insert($urandom_range(0, text.size() - 1), pick_sep(CHAR_DOT));
      end
      3: begin
        put_num($urandom_range(0, 255));
        add_char(CHAR_DOT);
        put_num($urandom_range(256, 999));
        put_text(".1.1~255.255.0.0");
      end
      default: repeat ($urandom_range(1, 8)) add_char(8'($urandom_range(0, 255)));
    endcase
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed lines: the extreme bytes, an ignored line with a trailing
    // separator, a value over 255, an empty field, a parse error that must
    // win over a zero first octet, and a valid line with nine fields.
    idle_on = 1'b1;
    add_char(8'hFF);
    send_line();
    add_char(8'h00);
    send_line();
    put_text("0");
    send_line();
    put_text("127.");
    send_line();
    put_text("999");
    send_line();
    put_text(".1");
    send_line();
    put_text("0x");
    send_line();
    put_text("10.0.0.1~255.0.0.0.7");
    send_line();

    chars_sent = 0;
    while (chars_sent < RANDOM_CHARS) begin
      idle_on = (RANDOM_CHARS - chars_sent > CALM_CHARS) && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 3) != 0) put_good_line();
      else put_broken_line();
      send_line();
    end
    push = 1'b0;
    idle_on = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
